// ----- design/rtb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtb_pkg: shared types and constants of the retransmit timer bank
// Action codes, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package rtb_pkg;

   localparam int unsigned SLOTS_DEFAULT = 1024;
   localparam int unsigned ACTION_W = 4;
   localparam int unsigned SEQ_W    = 10;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned RTO_W    = 24;
   localparam int unsigned AVG_W    = 24;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [RTO_W-1:0] RTO_RESET = 24'd1000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK      = 4'd0,
      ACT_WIN_START = 4'd1,
      ACT_WIN_STOP  = 4'd2,
      ACT_WIN_CHECK = 4'd3,
      ACT_FRM_START = 4'd4,
      ACT_FRM_STOP  = 4'd5,
      ACT_FRM_CHECK = 4'd6,
      ACT_REMAINING = 4'd7,
      ACT_EARLIEST  = 4'd8,
      ACT_RTT       = 4'd9,
      ACT_RTO       = 4'd10,
      ACT_CLEAR     = 4'd11
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_RTO_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_EMA   = 1'd1;

endpackage
`default_nettype wire

// ----- design/rtb_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtb_req_if / rtb_rsp_if / rtb_csr_if: word channels of the timer bank
// Valid/ready handshake with the payload fields of each channel.
// ----------------------------------------------------------------------------
interface rtb_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [9:0]  seq;
   logic [15:0] rtt_sample;
   modport source (output valid, action, seq, rtt_sample, input ready);
   modport sink   (input valid, action, seq, rtt_sample, output ready);
endinterface

interface rtb_rsp_if;
   logic        valid;
   logic        ready;
   logic        expired;
   logic [31:0] value;
   logic [31:0] win_start_cnt;
   logic [31:0] win_exp_cnt;
   logic [31:0] frm_start_cnt;
   logic [31:0] frm_exp_cnt;
   modport source (output valid, expired, value, win_start_cnt, win_exp_cnt,
                   frm_start_cnt, frm_exp_cnt, input ready);
   modport sink   (input valid, expired, value, win_start_cnt, win_exp_cnt,
                   frm_start_cnt, frm_exp_cnt, output ready);
endinterface

interface rtb_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/retransmit_timer_bank.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_timer_bank: bank of retransmission timers with averaged RTT
//
// req_ carries one command word (action, seq, rtt_sample); rsp_ returns one
// word per command: expired flag, value and the four stat counters after it.
// csr_ writes rto_ticks (index 0) and use_ema (index 1); write only while idle.
// After a command is accepted, the slot memory read (S_READ) and execute
// (S_EXEC) states come before rsp_valid (S_RESP). A later RTT sample
// passes through S_DIV for the divide by ten, done as a reciprocal
// multiply. The earliest-deadline scan reads one slot per cycle through
// the shared subtract/compare unit. A seq beyond the bank is folded back
// by repeated subtraction, each fold repeating S_READ (no fold when
// SLOTS >= 1024). One command at a time; req_ready returns the cycle
// after the response word is taken.
// Reset: a clearing pass marks every slot inactive, with req_ready low
// throughout. If rsp_ready is low, the result word is held and req_ready
// stays low until it is taken.
// ----------------------------------------------------------------------------
module retransmit_timer_bank #(
   parameter int unsigned SLOTS = rtb_pkg::SLOTS_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   rtb_req_if.sink   req,
   rtb_rsp_if.source rsp,
   rtb_csr_if.sink   csr
);

   localparam int unsigned SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
   localparam int unsigned SEQ_W    = rtb_pkg::SEQ_W;
   localparam int unsigned SEQ_SPAN = 1 << SEQ_W;
   // seq values at or above this are folded back into the bank
   localparam logic [SEQ_W:0] SEQ_LIM =
      (SEQ_W+1)'((SLOTS < SEQ_SPAN) ? SLOTS : SEQ_SPAN);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SCAN, S_DIV, S_RESP
   } state_type;

   state_type state_ff;
   rtb_pkg::action_type act_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [15:0]        sample_ff;

   logic [23:0] rto_ff;
   logic        use_ema_ff;
   logic [31:0] now_ff;
   logic        win_act_ff;
   logic [31:0] win_start_ff;
   // slot entry: active bit over start time
   logic [32:0] slot_mem [SLOTS];
   logic [32:0] rd_data_ff;
   logic [23:0] avg_ff;
   logic        seen_ff;
   logic [31:0] ws_ff, we_ff, fs_ff, fe_ff;

   logic        exp_ff;
   logic [31:0] val_ff;

   logic [CNT_W-1:0]  scan_ff;
   logic [27:0]       div_ff;

   logic rd_act;
   assign rd_act = rd_data_ff[32];

   // shared unit: elapsed from a start time against rto
   logic [31:0] su_start, su_elapsed, su_left;
   logic        su_exp;
   always_comb begin
      su_start   = (state_ff == S_EXEC && act_ff == rtb_pkg::ACT_WIN_CHECK)
                   ? win_start_ff : rd_data_ff[31:0];
      su_elapsed = now_ff - su_start;
      su_exp     = su_elapsed >= {8'd0, rto_ff};
      su_left    = su_exp ? 32'd0 : ({8'd0, rto_ff} - su_elapsed);
   end

   logic [SLOT_W-1:0] slot_addr, rd_addr, wr_addr;
   logic [32:0]       wr_data;
   logic              mem_we;
   assign slot_addr = SLOT_W'(seq_ff);
   assign rd_addr = (state_ff == S_SCAN || state_ff == S_EXEC)
                    ? SLOT_W'(scan_ff) : slot_addr;
   assign wr_addr = (state_ff == S_CLEAR) ? SLOT_W'(scan_ff) : slot_addr;
   assign mem_we = state_ff == S_CLEAR
                   || (state_ff == S_EXEC
                       && ((act_ff == rtb_pkg::ACT_FRM_START && !rd_act)
                           || act_ff == rtb_pkg::ACT_FRM_STOP));
   assign wr_data = {state_ff == S_EXEC && act_ff == rtb_pkg::ACT_FRM_START, now_ff};

   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[wr_addr] <= wr_data;
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign req.ready = state_ff == S_IDLE;
   assign csr.ready = 1'b1;
   assign rsp.valid = state_ff == S_RESP;
   assign rsp.expired = exp_ff;
   assign rsp.value = val_ff;
   assign rsp.win_start_cnt = ws_ff;
   assign rsp.win_exp_cnt = we_ff;
   assign rsp.frm_start_cnt = fs_ff;
   assign rsp.frm_exp_cnt = fe_ff;

   // 9*avg + sample*256, at most 28 bits
   logic [27:0] dividend;
   assign dividend = ({4'd0, avg_ff} << 3) + {4'd0, avg_ff} + {4'd0, sample_ff, 8'd0};
   // divide by ten: multiply by ceil(2^35/10), quotient from bit 35 up
   logic [63:0] recip_prod;
   assign recip_prod = {4'd0, div_ff} * 32'hCCCCCCCD;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff <= '0;
         rto_ff <= rtb_pkg::RTO_RESET;
         use_ema_ff <= 1'b0;
         now_ff <= '0;
         win_act_ff <= 1'b0;
         win_start_ff <= '0;
         avg_ff <= '0;
         seen_ff <= 1'b0;
         ws_ff <= '0; we_ff <= '0; fs_ff <= '0; fe_ff <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == rtb_pkg::CSR_RTO_TICKS) rto_ff <= csr.data;
            else use_ema_ff <= csr.data[0];
         end
         case (state_ff)
            S_CLEAR: begin
               if (scan_ff == CNT_W'(SLOTS - 1)) state_ff <= S_IDLE;
               scan_ff <= scan_ff + CNT_W'(1);
            end
            S_IDLE: begin
               if (req.valid) begin
                  act_ff <= rtb_pkg::action_type'(req.action);
                  seq_ff <= req.seq;
                  sample_ff <= req.rtt_sample;
                  exp_ff <= 1'b0;
                  val_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               scan_ff <= '0;
               if ({1'b0, seq_ff} >= SEQ_LIM) seq_ff <= seq_ff - SEQ_LIM[SEQ_W-1:0];
               else state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_RESP;
               case (act_ff)
                  rtb_pkg::ACT_TICK: now_ff <= now_ff + 32'd1;
                  rtb_pkg::ACT_WIN_START: if (!win_act_ff) begin
                     win_act_ff <= 1'b1;
                     win_start_ff <= now_ff;
                     ws_ff <= ws_ff + 32'd1;
                  end
                  rtb_pkg::ACT_WIN_STOP: win_act_ff <= 1'b0;
                  rtb_pkg::ACT_WIN_CHECK: if (win_act_ff && su_exp) begin
                     exp_ff <= 1'b1;
                     we_ff <= we_ff + 32'd1;
                  end
                  rtb_pkg::ACT_FRM_START: if (!rd_act) fs_ff <= fs_ff + 32'd1;
                  rtb_pkg::ACT_FRM_STOP: ;
                  rtb_pkg::ACT_FRM_CHECK: if (rd_act && su_exp) begin
                     exp_ff <= 1'b1;
                     fe_ff <= fe_ff + 32'd1;
                  end
                  rtb_pkg::ACT_REMAINING: val_ff <= rd_act ? su_left : 32'd0;
                  rtb_pkg::ACT_EARLIEST: begin
                     // read of slot 0 issued now; compare from next cycle
                     val_ff <= {8'd0, rto_ff};
                     scan_ff <= CNT_W'(1);
                     state_ff <= S_SCAN;
                  end
                  rtb_pkg::ACT_RTT: begin
                     if (!seen_ff) begin
                        avg_ff <= {sample_ff, 8'd0};
                        seen_ff <= 1'b1;
                     end else begin
                        div_ff <= dividend;
                        state_ff <= S_DIV;
                     end
                  end
                  rtb_pkg::ACT_RTO:
                     val_ff <= use_ema_ff ? {15'd0, avg_ff[23:7]} : {8'd0, rto_ff};
                  rtb_pkg::ACT_CLEAR: begin
                     ws_ff <= '0; we_ff <= '0; fs_ff <= '0; fe_ff <= '0;
                  end
                  default: ;
               endcase
            end
            S_SCAN: begin
               // rd_data_ff holds slot scan_ff-1
               if (rd_act && su_left < val_ff) val_ff <= su_left;
               if (scan_ff == CNT_W'(SLOTS)) state_ff <= S_RESP;
               else scan_ff <= scan_ff + CNT_W'(1);
            end
            S_DIV: begin
               avg_ff <= recip_prod[58:35];
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.value))
      else $error("result word dropped");
   a_exp_val: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.expired |-> rsp.value == 32'd0)
      else $error("expired with value");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |=> state_ff == S_RESP) else $error("divide overrun");
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req.ready) else $error("ready during clear");
`endif

endmodule
`default_nettype wire
